// ----- hdl/ascd_pkg.sv -----
// package for the ascii85 stream decoder: types, character and error codes
package ascd_pkg;

  typedef enum logic [3:0] {
    PH_OPEN0 = 4'b0001,
    PH_OPEN1 = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_TILDE = 4'b1000
  } phase_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_Z_GROUP  = 3'd2;
  localparam logic [2:0] ERR_LONE     = 3'd3;
  localparam logic [2:0] ERR_BAD_TERM = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  localparam logic [7:0] CH_CTRL_LO  = 8'd1;
  localparam logic [7:0] CH_CTRL_HI  = 8'd32;
  localparam logic [7:0] CH_DIGIT_LO = 8'd33;
  localparam logic [7:0] CH_DIGIT_HI = 8'd117;
  localparam logic [7:0] CH_HIGH_LO  = 8'd128;
  localparam logic [7:0] CH_HIGH_HI  = 8'd255;
  localparam logic [7:0] CH_Z        = 8'h7a;
  localparam logic [7:0] CH_TILDE    = 8'h7e;
  localparam logic [7:0] CH_GT       = 8'h3e;

  localparam logic [19:0] POW85_1 = 20'd85;
  localparam logic [19:0] POW85_2 = 20'd7225;
  localparam logic [19:0] POW85_3 = 20'd614125;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        has;
    logic        end_flag;
    logic [2:0]  err;
  } burst_t;

endpackage

// ----- hdl/ascd_step.sv -----
// decoder state and the per-item decision that forms a burst of results
module ascd_step import ascd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  output burst_t     burst
);

  phase_t      phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [32:0] group_value, group_value_next;

  logic [39:0] acc_full;
  logic [32:0] acc;
  logic [19:0] pad_mul;
  logic [45:0] pad_full;
  logic [32:0] pad_val;
  logic [7:0]  digit;

  always_comb begin
    digit    = ch - CH_DIGIT_LO;
    acc_full = {7'd0, group_value} * 40'd85 + {32'd0, digit};
    acc      = acc_full[32:0];
    case (digit_count)
      3'd2:    pad_mul = POW85_3;
      3'd3:    pad_mul = POW85_2;
      default: pad_mul = POW85_1;
    endcase
    pad_full = {20'd0, group_value[25:0]} * {26'd0, pad_mul}
             + {26'd0, pad_mul - 20'd1};
    pad_val  = pad_full[32:0];
  end

  always_comb begin
    burst            = '0;
    phase_next       = phase;
    digit_count_next = digit_count;
    group_value_next = group_value;
    case (phase)
      PH_OPEN0: phase_next = PH_OPEN1;
      PH_OPEN1: phase_next = PH_BODY;
      PH_TILDE: begin
        if (ch == CH_GT) begin
          phase_next       = PH_OPEN0;
          digit_count_next = 3'd0;
          group_value_next = '0;
          burst.end_flag   = 1'b1;
          if (digit_count == 3'd0) begin
            burst.count = 3'd1;
          end else if (digit_count == 3'd1) begin
            burst.count = 3'd1;
            burst.err   = ERR_LONE;
          end else begin
            burst.count = digit_count - 3'd1;
            burst.has   = 1'b1;
            burst.word  = pad_val[31:0];
            burst.err   = pad_val[32] ? ERR_OVERFLOW : ERR_NONE;
          end
        end else begin
          phase_next  = PH_BODY;
          burst.count = 3'd1;
          burst.err   = ERR_BAD_TERM;
        end
      end
      PH_BODY: begin
        if (ch inside {[CH_DIGIT_LO:CH_DIGIT_HI]}) begin
          if (digit_count == 3'd4) begin
            digit_count_next = 3'd0;
            group_value_next = '0;
            burst.count      = 3'd4;
            burst.has        = 1'b1;
            burst.word       = acc[31:0];
            burst.err        = acc[32] ? ERR_OVERFLOW : ERR_NONE;
          end else begin
            digit_count_next = digit_count + 3'd1;
            group_value_next = acc;
          end
        end else if (ch inside {[CH_CTRL_LO:CH_CTRL_HI], [CH_HIGH_LO:CH_HIGH_HI]}) begin
          burst = '0;
        end else if (ch == CH_Z) begin
          if (digit_count != 3'd0) begin
            burst.count = 3'd1;
            burst.err   = ERR_Z_GROUP;
          end else begin
            burst.count = 3'd4;
            burst.has   = 1'b1;
          end
        end else if (ch == CH_TILDE) begin
          phase_next = PH_TILDE;
        end else begin
          burst.count = 3'd1;
          burst.err   = ERR_BAD_CHAR;
        end
      end
      default: phase_next = PH_OPEN0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OPEN0;
      digit_count <= 3'd0;
      group_value <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      group_value <= group_value_next;
    end
  end

endmodule

// ----- hdl/ascd_out.sv -----
// result register that hands out a burst one item per cycle while out_stall is low
module ascd_out import ascd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  burst_t     burst,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       has_byte,
  output logic       end_of_stream,
  output logic [2:0] error_code
);

  logic [31:0] word;
  logic [2:0]  left;
  logic        has;
  logic        end_flag;
  logic [2:0]  err;
  logic        take;

  assign out_valid     = (left != 3'd0);
  assign take          = out_valid && !out_stall;
  assign can_load      = (left == 3'd0) || ((left == 3'd1) && !out_stall);
  assign data_byte     = word[31:24];
  assign has_byte      = has;
  assign end_of_stream = end_flag && (left == 3'd1);
  assign error_code    = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
    end else if (load) begin
      left <= burst.count;
    end else if (take) begin
      left <= left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word     <= burst.word;
      has      <= burst.has;
      end_flag <= burst.end_flag;
      err      <= burst.err;
    end else if (take) begin
      word <= {word[23:0], 8'h00};
    end
  end

endmodule

// ----- hdl/ascii85_stream_decoder.sv -----
// top level of the ascii85 stream decoder
//
//  channel  dir  handshake            fields
//  in       in   in_valid/in_stall    ch
//  out      out  out_valid/out_stall  data_byte, has_byte, end_of_stream, error_code
//
// one input item per cycle while in_stall is low; each item gives zero to four result items
// a group of five digits or a 'z' at a group boundary gives four results, which hold
// the input while the result register drains
// rst is synchronous; it returns the phase to PH_OPEN0 and clears the digit count and the result count
// out_stall reaches in_stall in the same cycle when the last pending result waits
module ascii85_stream_decoder import ascd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] data_byte,
  output logic       has_byte,
  output logic       end_of_stream,
  output logic [2:0] error_code,
  output logic       out_valid,
  input  logic       out_stall
);

  burst_t burst;
  logic   can_load;
  logic   accept;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  ascd_step u_step (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (ch),
    .burst  (burst)
  );

  ascd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .burst         (burst),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .data_byte     (data_byte),
    .has_byte      (has_byte),
    .end_of_stream (end_of_stream),
    .error_code    (error_code)
  );

endmodule
